@@ rtl/core/zbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbt_pkg
// Shared types, constants and tables of the 4x4 block transform unit:
// word type, negabinary mask, sequency order and the lifting micro-op table.
// ----------------------------------------------------------------------------
package zbt_pkg;

  localparam int unsigned WordW = 64;

  typedef logic [WordW-1:0] word_t;

  localparam word_t NbMask = 64'haaaa_aaaa_aaaa_aaaa;

  // lift register names
  localparam logic [1:0] RegX = 2'd0;
  localparam logic [1:0] RegY = 2'd1;
  localparam logic [1:0] RegZ = 2'd2;
  localparam logic [1:0] RegW = 2'd3;

  // one lifting micro-op: dst = (shl_a ? dst << 1 : dst) +/- (asr_b ? src >>> 1 : src),
  // optionally followed by an arithmetic shift right of the result
  typedef struct packed {
    logic [1:0] dst;
    logic [1:0] src;
    logic       sub;
    logic       shl_a;
    logic       asr_b;
    logic       asr_res;
  } lift_op_t;

  typedef struct packed {
    logic [3:0] load_addr;
    logic [3:0] in_raddr;
    logic [3:0] work_raddr;
    logic       work_we;
    logic [3:0] work_waddr;
    logic       copy_sel;
    logic       inv;
    logic       cap_en;
    logic [1:0] cap_idx;
    logic       op_en;
    lift_op_t   op;
    logic [1:0] wr_idx;
    logic       emit_cap;
    logic       emit_last;
  } ctrl_t;

  function automatic logic [3:0] seq_addr(logic [3:0] idx);
    logic [3:0] res;
    case (idx)
      4'd0:    res = 4'd0;
      4'd1:    res = 4'd1;
      4'd2:    res = 4'd4;
      4'd3:    res = 4'd5;
      4'd4:    res = 4'd2;
      4'd5:    res = 4'd8;
      4'd6:    res = 4'd6;
      4'd7:    res = 4'd9;
      4'd8:    res = 4'd3;
      4'd9:    res = 4'd12;
      4'd10:   res = 4'd10;
      4'd11:   res = 4'd7;
      4'd12:   res = 4'd13;
      4'd13:   res = 4'd11;
      4'd14:   res = 4'd14;
      default: res = 4'd15;
    endcase
    return res;
  endfunction

  function automatic lift_op_t mk_op(logic [1:0] dst, logic [1:0] src, logic sub,
                                     logic shl_a, logic asr_b, logic asr_res);
    lift_op_t op;
    op.dst     = dst;
    op.src     = src;
    op.sub     = sub;
    op.shl_a   = shl_a;
    op.asr_b   = asr_b;
    op.asr_res = asr_res;
    return op;
  endfunction

  function automatic lift_op_t lift_op(logic inv, logic [3:0] step);
    lift_op_t op;
    if (!inv) begin
      case (step)
        4'd0:    op = mk_op(RegX, RegW, 1'b0, 1'b0, 1'b0, 1'b1);
        4'd1:    op = mk_op(RegW, RegX, 1'b1, 1'b0, 1'b0, 1'b0);
        4'd2:    op = mk_op(RegZ, RegY, 1'b0, 1'b0, 1'b0, 1'b1);
        4'd3:    op = mk_op(RegY, RegZ, 1'b1, 1'b0, 1'b0, 1'b0);
        4'd4:    op = mk_op(RegX, RegZ, 1'b0, 1'b0, 1'b0, 1'b1);
        4'd5:    op = mk_op(RegZ, RegX, 1'b1, 1'b0, 1'b0, 1'b0);
        4'd6:    op = mk_op(RegW, RegY, 1'b0, 1'b0, 1'b0, 1'b1);
        4'd7:    op = mk_op(RegY, RegW, 1'b1, 1'b0, 1'b0, 1'b0);
        4'd8:    op = mk_op(RegW, RegY, 1'b0, 1'b0, 1'b1, 1'b0);
        default: op = mk_op(RegY, RegW, 1'b1, 1'b0, 1'b1, 1'b0);
      endcase
    end else begin
      case (step)
        4'd0:    op = mk_op(RegY, RegW, 1'b0, 1'b0, 1'b1, 1'b0);
        4'd1:    op = mk_op(RegW, RegY, 1'b1, 1'b0, 1'b1, 1'b0);
        4'd2:    op = mk_op(RegY, RegW, 1'b0, 1'b0, 1'b0, 1'b0);
        4'd3:    op = mk_op(RegW, RegY, 1'b1, 1'b1, 1'b0, 1'b0);
        4'd4:    op = mk_op(RegZ, RegX, 1'b0, 1'b0, 1'b0, 1'b0);
        4'd5:    op = mk_op(RegX, RegZ, 1'b1, 1'b1, 1'b0, 1'b0);
        4'd6:    op = mk_op(RegY, RegZ, 1'b0, 1'b0, 1'b0, 1'b0);
        4'd7:    op = mk_op(RegZ, RegY, 1'b1, 1'b1, 1'b0, 1'b0);
        4'd8:    op = mk_op(RegW, RegX, 1'b0, 1'b0, 1'b0, 1'b0);
        default: op = mk_op(RegX, RegW, 1'b1, 1'b1, 1'b0, 1'b0);
      endcase
    end
    return op;
  endfunction

endpackage

@@ rtl/core/zbt_lift_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbt_lift_alu
// Shared lifting unit: one 64-bit add or subtract with optional shifts on
// the operands and the result.
// ----------------------------------------------------------------------------
module zbt_lift_alu
  import zbt_pkg::*;
(
  input  word_t    a_i,
  input  word_t    b_i,
  input  lift_op_t op_i,
  output word_t    res_o
);

  word_t a_eff;
  word_t b_eff;
  word_t sum;

  assign a_eff = op_i.shl_a ? {a_i[WordW-2:0], 1'b0} : a_i;
  assign b_eff = op_i.asr_b ? {b_i[WordW-1], b_i[WordW-1:1]} : b_i;
  assign sum   = op_i.sub ? (a_eff - b_eff) : (a_eff + b_eff);
  assign res_o = op_i.asr_res ? {sum[WordW-1], sum[WordW-1:1]} : sum;

endmodule

@@ rtl/core/zbt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbt_ctrl
// Sequencer: word loading, copy into the work store, eight lifting passes
// (read, ten micro-ops, write back) and the sixteen-word emit sweep.
// ----------------------------------------------------------------------------
module zbt_ctrl
  import zbt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  direction_i,
  output logic  busy,
  output ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COPY,
    ST_RD,
    ST_OP,
    ST_WR,
    ST_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [2:0] pass_q, pass_d;
  logic [3:0] load_cnt_q, load_cnt_d;
  logic       inv_q, inv_d;

  logic       accept;
  logic [3:0] cnt_m1;
  logic       row_pass;

  assign busy     = (state_q != ST_LOAD);
  assign accept   = start && !busy;
  assign cnt_m1   = 4'(cnt_q - 5'd1);
  assign row_pass = (pass_q[2] == inv_q);

  function automatic logic [3:0] elem_addr(logic row, logic [1:0] i, logic [1:0] j);
    return row ? {i, j} : {j, i};
  endfunction

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pass_d     = pass_q;
    load_cnt_d = load_cnt_q;
    inv_d      = inv_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          load_cnt_d = load_cnt_q + 4'd1;
          if (load_cnt_q == 4'd15) begin
            inv_d   = direction_i;
            state_d = ST_COPY;
            cnt_d   = 5'd0;
          end
        end
      end
      ST_COPY: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          state_d = ST_RD;
          cnt_d   = 5'd0;
          pass_d  = 3'd0;
        end
      end
      ST_RD: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd4) begin
          state_d = ST_OP;
          cnt_d   = 5'd0;
        end
      end
      ST_OP: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd9) begin
          state_d = ST_WR;
          cnt_d   = 5'd0;
        end
      end
      ST_WR: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd3) begin
          cnt_d  = 5'd0;
          pass_d = pass_q + 3'd1;
          if (pass_q == 3'd7) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_EMIT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          state_d = ST_LOAD;
          cnt_d   = 5'd0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.load_addr  = load_cnt_q;
    ctrl_o.in_raddr   = cnt_q[3:0];
    ctrl_o.inv        = inv_q;
    ctrl_o.op         = lift_op(inv_q, cnt_q[3:0]);
    case (state_q)
      ST_COPY: begin
        ctrl_o.work_we    = (cnt_q != 5'd0);
        ctrl_o.work_waddr = inv_q ? seq_addr(cnt_m1) : cnt_m1;
        ctrl_o.copy_sel   = 1'b1;
      end
      ST_RD: begin
        ctrl_o.work_raddr = elem_addr(row_pass, pass_q[1:0], cnt_q[1:0]);
        ctrl_o.cap_en     = (cnt_q != 5'd0);
        ctrl_o.cap_idx    = cnt_m1[1:0];
      end
      ST_OP: begin
        ctrl_o.op_en = 1'b1;
      end
      ST_WR: begin
        ctrl_o.work_we    = 1'b1;
        ctrl_o.work_waddr = elem_addr(row_pass, pass_q[1:0], cnt_q[1:0]);
        ctrl_o.wr_idx     = cnt_q[1:0];
      end
      ST_EMIT: begin
        ctrl_o.work_raddr = inv_q ? cnt_q[3:0] : seq_addr(cnt_q[3:0]);
        ctrl_o.emit_cap   = (cnt_q != 5'd0);
        ctrl_o.emit_last  = (cnt_q == 5'd16);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      pass_q     <= '0;
      load_cnt_q <= '0;
      inv_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pass_q     <= pass_d;
      load_cnt_q <= load_cnt_d;
      inv_q      <= inv_d;
    end
  end

endmodule

@@ rtl/core/zfp_block_transform_4x4_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfp_block_transform_4x4_unit
// 4x4 block decorrelating transform with negabinary mapping, forward and
// inverse, built around one shared 64-bit lifting unit.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+---------------------------
//  config   | cfg_we_i, cfg_wdata_i                   | edge with cfg_we_i high
//  input    | start, busy, sample_word_i              | edge with start & !busy
//  result   | out_valid_o, out_word_o, out_last_o     | every cycle out_valid_o high
//
//  Words load one per cycle. After the sixteenth the unit is busy through
//  the copy, eight passes (4 reads, 10 lift ops on the shared adder, 4 write-backs
//  and a fill) and the emit sweep. The sixteen results strobe on consecutive
//  cycles, the last one in the first cycle after busy drops. Reset clears
//  control, the direction bit and the result flags only; the stores need no
//  clearing. The receiver cannot stall results.
module zfp_block_transform_4x4_unit
  import zbt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  input  logic  start,
  input  word_t sample_word_i,
  output logic  busy,
  output logic  out_valid_o,
  output word_t out_word_o,
  output logic  out_last_o
);

  ctrl_t ctrl;
  logic  direction_q;

  word_t in_mem   [16];
  word_t work_mem [16];
  word_t in_rd_q;
  word_t work_rd_q;
  word_t work_wdata;

  word_t x_q, y_q, z_q, w_q;
  word_t a_val, b_val, wr_val, alu_res;

  logic  out_valid_q, out_last_q;
  word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
    end else if (cfg_we_i) begin
      direction_q <= cfg_wdata_i;
    end
  end

  zbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .direction_i (direction_q),
    .busy        (busy),
    .ctrl_o      (ctrl)
  );

  function automatic word_t sel_reg(logic [1:0] idx, word_t x, word_t y, word_t z, word_t w);
    word_t res;
    case (idx)
      RegX:    res = x;
      RegY:    res = y;
      RegZ:    res = z;
      default: res = w;
    endcase
    return res;
  endfunction

  assign a_val  = sel_reg(ctrl.op.dst, x_q, y_q, z_q, w_q);
  assign b_val  = sel_reg(ctrl.op.src, x_q, y_q, z_q, w_q);
  assign wr_val = sel_reg(ctrl.wr_idx, x_q, y_q, z_q, w_q);

  zbt_lift_alu u_alu (
    .a_i   (a_val),
    .b_i   (b_val),
    .op_i  (ctrl.op),
    .res_o (alu_res)
  );

  // input store
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_mem[ctrl.load_addr] <= sample_word_i;
    end
    in_rd_q <= in_mem[ctrl.in_raddr];
  end

  // copy path applies negabinary-to-signed for inverse blocks
  always_comb begin
    if (ctrl.copy_sel) begin
      work_wdata = ctrl.inv ? ((in_rd_q ^ NbMask) - NbMask) : in_rd_q;
    end else begin
      work_wdata = wr_val;
    end
  end

  // work store
  always_ff @(posedge clk_i) begin
    if (ctrl.work_we) begin
      work_mem[ctrl.work_waddr] <= work_wdata;
    end
    work_rd_q <= work_mem[ctrl.work_raddr];
  end

  // lift registers
  always_ff @(posedge clk_i) begin
    if (ctrl.cap_en) begin
      case (ctrl.cap_idx)
        RegX:    x_q <= work_rd_q;
        RegY:    y_q <= work_rd_q;
        RegZ:    z_q <= work_rd_q;
        default: w_q <= work_rd_q;
      endcase
    end else if (ctrl.op_en) begin
      case (ctrl.op.dst)
        RegX:    x_q <= alu_res;
        RegY:    y_q <= alu_res;
        RegZ:    z_q <= alu_res;
        default: w_q <= alu_res;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= ctrl.emit_cap;
      out_last_q  <= ctrl.emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit_cap) begin
      out_word_q <= ctrl.inv ? work_rd_q : ((work_rd_q + NbMask) ^ NbMask);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_last_with_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_last_o |-> out_valid_o)
    else $error("last flag without result strobe");

  a_last_ends_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_last_o |=> !out_valid_o)
    else $error("result strobe after last word of block");

  a_busy_mid_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |-> busy)
    else $error("unit idle while results of a block are still pending");

  a_idle_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> out_last_o)
    else $error("busy dropped without the last result transfer");
`endif

endmodule
